### src/vvps_pkg.sv
// Package for the velocity Verlet particle step: word format, request codes,
// and the input and result transaction structs. No dependencies.
`default_nettype none
package vvps_pkg;
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;

    localparam logic REQ_FIRST  = 1'b0;
    localparam logic REQ_SECOND = 1'b1;

    localparam logic [WORD_BITS-1:0] DT_RESET = WORD_BITS'(655);

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic [WORD_BITS-1:0]        t_uword;

    typedef struct packed {
        logic   req_type;
        t_word  pos_x;
        t_word  pos_y;
        t_word  pos_z;
        t_word  vel_x;
        t_word  vel_y;
        t_word  vel_z;
        t_word  vector_x;
        t_word  vector_y;
        t_word  vector_z;
        t_uword mass;
    } t_vvps_in;

    typedef struct packed {
        t_word new_pos_x;
        t_word new_pos_y;
        t_word new_pos_z;
        t_word new_vel_x;
        t_word new_vel_y;
        t_word new_vel_z;
        t_word new_acc_x;
        t_word new_acc_y;
        t_word new_acc_z;
        logic  saturated;
        logic  zero_mass;
    } t_vvps_out;
endpackage
`default_nettype wire

### src/vvps_div.sv
// Pipelined restoring divider: (mag << FRAC_BITS) / den, STEPS quotient bits per stage.
// Depends on vvps_pkg.
`default_nettype none
module vvps_div #(
    parameter int STEPS = 4
) (
    input  wire logic                           i_clk,
    input  wire logic [vvps_pkg::WORD_BITS-1:0] i_mag,
    input  wire logic [vvps_pkg::WORD_BITS-1:0] i_den,
    output logic      [vvps_pkg::QUO_BITS-1:0]  o_quo,
    output logic      [vvps_pkg::WORD_BITS:0]   o_rem
);
    import vvps_pkg::*;

    localparam int NSTG = (QUO_BITS + STEPS - 1) / STEPS;

    logic [WORD_BITS:0]   r_rem [NSTG];
    logic [QUO_BITS-1:0]  r_quo [NSTG];
    logic [QUO_BITS-1:0]  r_dnd [NSTG];
    logic [WORD_BITS-1:0] r_den [NSTG];
    logic [WORD_BITS:0]   s_rem [NSTG];
    logic [QUO_BITS-1:0]  s_quo [NSTG];
    logic [QUO_BITS-1:0]  s_dnd [NSTG];
    logic [WORD_BITS-1:0] s_den [NSTG];
    logic [WORD_BITS:0]   n_rem [NSTG];
    logic [QUO_BITS-1:0]  n_quo [NSTG];
    logic [QUO_BITS-1:0]  n_dnd [NSTG];
    logic [WORD_BITS-1:0] n_den [NSTG];

    genvar s;
    generate
        for (s = 0; s < NSTG; s++) begin : g_stg
            if (s == 0) begin : g_head
                assign s_rem[s] = '0;
                assign s_quo[s] = '0;
                assign s_dnd[s] = {i_mag, {FRAC_BITS{1'b0}}};
                assign s_den[s] = i_den;
            end else begin : g_body
                assign s_rem[s] = r_rem[s-1];
                assign s_quo[s] = r_quo[s-1];
                assign s_dnd[s] = r_dnd[s-1];
                assign s_den[s] = r_den[s-1];
            end

            always_comb begin
                n_rem[s] = s_rem[s];
                n_quo[s] = s_quo[s];
                n_dnd[s] = s_dnd[s];
                n_den[s] = s_den[s];
                for (int k = 0; k < STEPS; k++) begin
                    if (s * STEPS + k < QUO_BITS) begin
                        n_rem[s] = {n_rem[s][WORD_BITS-1:0], n_dnd[s][QUO_BITS-1]};
                        n_dnd[s] = {n_dnd[s][QUO_BITS-2:0], 1'b0};
                        n_quo[s] = {n_quo[s][QUO_BITS-2:0], 1'b0};
                        if (n_rem[s] >= {1'b0, n_den[s]}) begin
                            n_rem[s]    = n_rem[s] - {1'b0, n_den[s]};
                            n_quo[s][0] = 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_dnd[s] <= n_dnd[s];
                r_den[s] <= n_den[s];
            end
        end
    endgenerate

    assign o_quo = r_quo[NSTG-1];
    assign o_rem = r_rem[NSTG-1];
endmodule
`default_nettype wire

### src/velocity_verlet_particle_step.sv
// Velocity Verlet half step for one particle per transaction, Q16.16 fixed point.
// Depends on vvps_pkg and vvps_div.
//
//  channel   signals                                   direction
//  request   i_start, o_busy, i_req                    in
//  result    o_valid, o_res                            out
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data      in
//
// One transaction enters per cycle; o_busy stays low.
// The path runs through the three parallel divider pipelines (force / mass),
// then the acc, multiply, partial, sum and output registers.
// Reset clears the valid bits and loads dt with 655.
// The result is shown for one cycle on o_valid; the receiver cannot stall.
`default_nettype none
module velocity_verlet_particle_step #(
    parameter int DIV_STEPS = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire vvps_pkg::t_vvps_in           i_req,
    output logic                              o_valid,
    output vvps_pkg::t_vvps_out               o_res,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [vvps_pkg::WORD_BITS-1:0] i_cfg_data
);
    import vvps_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int NSTG = (QUO_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int LAT  = NSTG + 5;
    localparam int KW   = 2 * W + F + 4;
    localparam int NW   = 3 * W + F + 4;

    localparam logic signed [KW-1:0] K_HALF = KW'(1) <<< F;
    localparam logic signed [NW-1:0] D_HALF = NW'(1) <<< (2 * F);
    localparam logic [QUO_BITS:0]    Q_HALF = (QUO_BITS+1)'(1) << (W - 1);
    localparam t_word W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam t_word W_MIN = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0] r_dt;
    logic signed [W:0] dt_s;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign dt_s        = $signed({1'b0, r_dt});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= DT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dt <= i_cfg_data;
        end
    end

    // divider front
    t_word        in_x [3];
    logic [W-1:0] in_mag [3];
    logic [QUO_BITS-1:0] dv_quo [3];
    logic [W:0]          dv_rem [3];

    assign in_x[0] = i_req.vector_x;
    assign in_x[1] = i_req.vector_y;
    assign in_x[2] = i_req.vector_z;

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_div
            assign in_mag[c] = in_x[c][W-1] ? W'(-in_x[c]) : in_x[c];
            vvps_div #(.STEPS(DIV_STEPS)) u_div (
                .i_clk (i_clk),
                .i_mag (in_mag[c]),
                .i_den (i_req.mass),
                .o_quo (dv_quo[c]),
                .o_rem (dv_rem[c])
            );
        end
    endgenerate

    logic     r_dv_vld [NSTG];
    t_vvps_in r_dv_req [NSTG];

    genvar s;
    generate
        for (s = 0; s < NSTG; s++) begin : g_dly
            if (s == 0) begin : g_head
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_dv_vld[s] <= 1'b0;
                    end else begin
                        r_dv_vld[s] <= i_start && !o_busy;
                    end
                    r_dv_req[s] <= i_req;
                end
            end else begin : g_body
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_dv_vld[s] <= 1'b0;
                    end else begin
                        r_dv_vld[s] <= r_dv_vld[s-1];
                    end
                    r_dv_req[s] <= r_dv_req[s-1];
                end
            end
        end
    endgenerate

    // stage A: acceleration
    t_vvps_in dq;
    t_word    a_x [3];
    t_word    a_v [3];
    t_word    a_p [3];
    t_word    n_a_acc [3];
    logic     n_a_sat;
    logic     n_a_zm;
    logic [QUO_BITS:0] qr [3];

    assign dq     = r_dv_req[NSTG-1];
    assign a_x[0] = dq.vector_x;
    assign a_x[1] = dq.vector_y;
    assign a_x[2] = dq.vector_z;
    assign a_v[0] = dq.vel_x;
    assign a_v[1] = dq.vel_y;
    assign a_v[2] = dq.vel_z;
    assign a_p[0] = dq.pos_x;
    assign a_p[1] = dq.pos_y;
    assign a_p[2] = dq.pos_z;

    always_comb begin
        n_a_sat = 1'b0;
        n_a_zm  = (dq.req_type == REQ_SECOND) && (dq.mass == '0);
        for (int k = 0; k < 3; k++) begin
            qr[k] = {1'b0, dv_quo[k]}
                  + (QUO_BITS+1)'({dv_rem[k], 1'b0} >= {2'b00, dq.mass});
            if (dq.req_type == REQ_FIRST) begin
                n_a_acc[k] = a_x[k];
            end else if (n_a_zm) begin
                n_a_acc[k] = '0;
            end else if (a_x[k][W-1]) begin
                if (qr[k] > Q_HALF) begin
                    n_a_acc[k] = W_MIN;
                    n_a_sat    = 1'b1;
                end else begin
                    n_a_acc[k] = W'(-qr[k][W-1:0]);
                end
            end else begin
                if (qr[k] > Q_HALF - 1'b1) begin
                    n_a_acc[k] = W_MAX;
                    n_a_sat    = 1'b1;
                end else begin
                    n_a_acc[k] = qr[k][W-1:0];
                end
            end
        end
    end

    logic  r_a_vld, r_a_type, r_a_sat, r_a_zm;
    t_word r_a_acc [3];
    t_word r_a_v [3];
    t_word r_a_p [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= r_dv_vld[NSTG-1];
        end
        r_a_type <= dq.req_type;
        r_a_sat  <= n_a_sat;
        r_a_zm   <= n_a_zm;
        r_a_acc  <= n_a_acc;
        r_a_v    <= a_v;
        r_a_p    <= a_p;
    end

    // stage B: acc * dt, v * dt
    logic  r_b_vld, r_b_type, r_b_sat, r_b_zm;
    t_word r_b_acc [3];
    t_word r_b_v [3];
    t_word r_b_p [3];
    logic signed [2*W:0] r_b_ad [3];
    logic signed [2*W:0] r_b_vd [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_type <= r_a_type;
        r_b_sat  <= r_a_sat;
        r_b_zm   <= r_a_zm;
        r_b_acc  <= r_a_acc;
        r_b_v    <= r_a_v;
        r_b_p    <= r_a_p;
        for (int k = 0; k < 3; k++) begin
            r_b_ad[k] <= (2*W+1)'(r_a_acc[k]) * (2*W+1)'(dt_s);
            r_b_vd[k] <= (2*W+1)'(r_a_v[k]) * (2*W+1)'(dt_s);
        end
    end

    // stage C: kick, a*dt*dt partial products
    logic signed [KW-1:0] kn [3];
    t_word n_c_vel [3];
    logic  n_c_sat;

    always_comb begin
        n_c_sat = r_b_sat;
        for (int k = 0; k < 3; k++) begin
            kn[k] = ((KW'(r_b_v[k]) <<< (F + 1)) + KW'(r_b_ad[k]) + K_HALF) >>> (F + 1);
            if ((&kn[k][KW-1:W-1]) || !(|kn[k][KW-1:W-1])) begin
                n_c_vel[k] = kn[k][W-1:0];
            end else begin
                n_c_vel[k] = kn[k][KW-1] ? W_MIN : W_MAX;
                n_c_sat    = 1'b1;
            end
        end
    end

    logic  r_c_vld, r_c_type, r_c_sat, r_c_zm;
    t_word r_c_acc [3];
    t_word r_c_vel [3];
    t_word r_c_p [3];
    logic signed [2*W:0]   r_c_vd [3];
    logic signed [2*W+1:0] r_c_hp [3];
    logic signed [2*W+1:0] r_c_lp [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_type <= r_b_type;
        r_c_sat  <= n_c_sat;
        r_c_zm   <= r_b_zm;
        r_c_acc  <= r_b_acc;
        r_c_vel  <= n_c_vel;
        r_c_p    <= r_b_p;
        r_c_vd   <= r_b_vd;
        for (int k = 0; k < 3; k++) begin
            r_c_hp[k] <= (2*W+2)'($signed(r_b_ad[k][2*W:W])) * (2*W+2)'(dt_s);
            r_c_lp[k] <= (2*W+2)'($signed({1'b0, r_b_ad[k][W-1:0]})) * (2*W+2)'(dt_s);
        end
    end

    // stage D: drift sum
    logic  r_d_vld, r_d_type, r_d_sat, r_d_zm;
    t_word r_d_acc [3];
    t_word r_d_vel [3];
    t_word r_d_p [3];
    logic signed [NW-1:0] r_d_sum [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_type <= r_c_type;
        r_d_sat  <= r_c_sat;
        r_d_zm   <= r_c_zm;
        r_d_acc  <= r_c_acc;
        r_d_vel  <= r_c_vel;
        r_d_p    <= r_c_p;
        for (int k = 0; k < 3; k++) begin
            r_d_sum[k] <= ((NW'(r_c_vd[k]) <<< (F + 1)) + (NW'(r_c_hp[k]) <<< W)
                         + NW'(r_c_lp[k]) + (NW'(r_c_p[k]) <<< (2 * F + 1)) + D_HALF)
                         >>> (2 * F + 1);
        end
    end

    // stage E: saturate position, output register
    t_word     n_e_pos [3];
    logic      n_e_sat;
    t_vvps_out n_res;

    always_comb begin
        n_e_sat = r_d_sat;
        for (int k = 0; k < 3; k++) begin
            if (r_d_type == REQ_SECOND) begin
                n_e_pos[k] = r_d_p[k];
            end else if ((&r_d_sum[k][NW-1:W-1]) || !(|r_d_sum[k][NW-1:W-1])) begin
                n_e_pos[k] = r_d_sum[k][W-1:0];
            end else begin
                n_e_pos[k] = r_d_sum[k][NW-1] ? W_MIN : W_MAX;
                n_e_sat    = 1'b1;
            end
        end
        n_res.new_pos_x = n_e_pos[0];
        n_res.new_pos_y = n_e_pos[1];
        n_res.new_pos_z = n_e_pos[2];
        n_res.new_vel_x = r_d_vel[0];
        n_res.new_vel_y = r_d_vel[1];
        n_res.new_vel_z = r_d_vel[2];
        n_res.new_acc_x = r_d_acc[0];
        n_res.new_acc_y = r_d_acc[1];
        n_res.new_acc_z = r_d_acc[2];
        n_res.saturated = n_e_sat;
        n_res.zero_mass = r_d_zm;
    end

    logic      r_valid;
    t_vvps_out r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_d_vld;
        end
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("result without a transaction LAT cycles earlier");

    a_zm_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.zero_mass |->
            o_res.new_acc_x == '0 && o_res.new_acc_y == '0 && o_res.new_acc_z == '0)
        else $error("zero mass with nonzero acceleration");

    a_zm_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.zero_mass |-> !o_res.saturated)
        else $error("zero mass result flagged saturated");
endmodule
`default_nettype wire
